FILE: rtl/core/tqwa_pkg.sv
// -----------------------------------------------------------------------------
// tqwa_pkg
// Shared constants, codes and types of the two-queue weighted arbiter.
// -----------------------------------------------------------------------------
`default_nettype none

package tqwa_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned FillW      = $clog2(QueueDepth + 1);
  localparam int unsigned ItemWidth  = 32;

  // Field widths
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned BurstW  = 4;

  localparam logic [BurstW-1:0] BurstReset = BurstW'(3);

  typedef enum logic [OpW-1:0] {
    OP_ENQ_PRIO = 2'd0,
    OP_ENQ_NORM = 2'd1,
    OP_SERVE    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_PRIO = 2'd0,
    ST_NORM = 2'd1,
    ST_WAIT = 2'd2,
    ST_DROP = 2'd3
  } status_e;

  // Occupancy flags of one queue
  typedef struct packed {
    logic empty;
    logic full;
  } queue_flags_t;

endpackage

`default_nettype wire

FILE: rtl/core/tqwa_in_if.sv
// -----------------------------------------------------------------------------
// tqwa_in_if
// Request channel: enqueue or serve beats with valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface tqwa_in_if;
  import tqwa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OpW-1:0]       operation;
  logic [ItemWidth-1:0] item_value;

  modport source (output valid, output operation, output item_value, input ready);
  modport sink   (input valid, input operation, input item_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tqwa_out_if.sv
// -----------------------------------------------------------------------------
// tqwa_out_if
// Result channel: status and served value with valid/ready handshake.
// -----------------------------------------------------------------------------
`default_nettype none

interface tqwa_out_if;
  import tqwa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic [ItemWidth-1:0] served_value;

  modport source (output valid, output status, output served_value, input ready);
  modport sink   (input valid, input status, input served_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tqwa_cfg_if.sv
// -----------------------------------------------------------------------------
// tqwa_cfg_if
// Configuration write channel carrying the priority burst register.
// -----------------------------------------------------------------------------
`default_nettype none

interface tqwa_cfg_if;
  import tqwa_pkg::*;

  logic              valid;
  logic              ready;
  logic [BurstW-1:0] priority_burst;

  modport source (output valid, output priority_burst, input ready);
  modport sink   (input valid, input priority_burst, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/two_queue_weighted_arbiter.sv
// -----------------------------------------------------------------------------
// two_queue_weighted_arbiter
// Priority and normal FIFOs with a burst-weighted serve decision.
// -----------------------------------------------------------------------------
// Requests arrive on in_ch: enqueue priority, enqueue normal, or serve. A
// successful enqueue gives no result; an enqueue into a full queue gives one
// beat with status dropped. A serve always gives one beat: wait when both
// queues are empty, otherwise a priority item while the burst count lasts (or
// while the normal queue is empty), else one normal item, which reloads the
// burst count from priority_burst. The decision is taken when the request is
// accepted and the item comes out of the queue RAM's registered read
// straight into the result beat, so the block takes one request per cycle;
// a request waits only while a finished result is held by the sink.
// Write priority_burst on cfg_ch; it takes effect at the next reload.
`default_nettype none

module two_queue_weighted_arbiter (
  input wire logic clk_i,
  input wire logic rst_ni,
  tqwa_in_if.sink    in_ch,
  tqwa_out_if.source out_ch,
  tqwa_cfg_if.sink   cfg_ch
);
  import tqwa_pkg::*;

  logic                 in_acc;
  logic                 has_result;
  status_e              status_d, status_q;
  logic                 out_valid_q, out_valid_d;
  logic [BurstW-1:0]    burst_cfg_q;
  logic [BurstW-1:0]    burst_left_q, burst_left_d;
  logic                 push_p, push_n, pop_p, pop_n;
  logic [ItemWidth-1:0] data_p, data_n;
  queue_flags_t         flags_p, flags_n;

  // Accept when the result register is free or drains this cycle
  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // Configuration register is always writable
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cfg_q <= BurstReset;
    end else if (cfg_ch.valid) begin
      burst_cfg_q <= cfg_ch.priority_burst;
    end
  end

  // Decide push, pop, result and burst update for the accepted request
  always_comb begin
    push_p       = 1'b0;
    push_n       = 1'b0;
    pop_p        = 1'b0;
    pop_n        = 1'b0;
    has_result   = 1'b0;
    status_d     = ST_WAIT;
    burst_left_d = burst_left_q;
    if (in_acc) begin
      case (op_e'(in_ch.operation))
        OP_ENQ_PRIO: begin
          if (flags_p.full) begin
            has_result = 1'b1;
            status_d   = ST_DROP;
          end else begin
            push_p = 1'b1;
          end
        end
        OP_ENQ_NORM: begin
          if (flags_n.full) begin
            has_result = 1'b1;
            status_d   = ST_DROP;
          end else begin
            push_n = 1'b1;
          end
        end
        OP_SERVE: begin
          has_result = 1'b1;
          if (flags_p.empty && flags_n.empty) begin
            status_d = ST_WAIT;
          end else if (!flags_p.empty && (burst_left_q != '0 || flags_n.empty)) begin
            status_d = ST_PRIO;
            pop_p    = 1'b1;
            if (burst_left_q != '0) begin
              burst_left_d = burst_left_q - BurstW'(1);
            end
          end else begin
            status_d     = ST_NORM;
            pop_n        = 1'b1;
            burst_left_d = burst_cfg_q;
          end
        end
        default: has_result = 1'b0;
      endcase
    end
  end

  // Result register: load on a new result, drop when taken
  always_comb begin
    if (in_acc && has_result) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      burst_left_q <= BurstReset;
    end else begin
      out_valid_q  <= out_valid_d;
      burst_left_q <= burst_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && has_result) begin
      status_q <= status_d;
    end
  end

  // Queues
  tqwa_queue u_prio_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_p),
    .push_data_i (in_ch.item_value),
    .pop_i       (pop_p),
    .pop_data_o  (data_p),
    .flags_o     (flags_p)
  );

  tqwa_queue u_norm_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_n),
    .push_data_i (in_ch.item_value),
    .pop_i       (pop_n),
    .pop_data_o  (data_n),
    .flags_o     (flags_n)
  );

  // Drive the result beat; RAM read data holds while the beat is stalled
  assign out_ch.valid  = out_valid_q;
  assign out_ch.status = status_q;

  always_comb begin
    case (status_q)
      ST_PRIO: out_ch.served_value = data_p;
      ST_NORM: out_ch.served_value = data_n;
      default: out_ch.served_value = '0;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/tqwa_ram.sv
// -----------------------------------------------------------------------------
// tqwa_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none

module tqwa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/tqwa_queue.sv
// -----------------------------------------------------------------------------
// tqwa_queue
// Circular FIFO: head and fill counters around one RAM.
// -----------------------------------------------------------------------------
`default_nettype none

module tqwa_queue (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic [tqwa_pkg::ItemWidth-1:0] push_data_i,
  input  wire logic                           pop_i,
  output      logic [tqwa_pkg::ItemWidth-1:0] pop_data_o,
  output      tqwa_pkg::queue_flags_t         flags_o
);
  import tqwa_pkg::*;

  logic [PtrW-1:0]  head_q, head_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [FillW:0]   tail_sum;
  logic [PtrW-1:0]  tail;

  // Occupancy
  assign flags_o.empty = (fill_q == '0);
  assign flags_o.full  = (fill_q == FillW'(QueueDepth));

  // Write slot: head plus fill, wrapped once
  always_comb begin
    tail_sum = {1'b0, {(FillW - PtrW){1'b0}}, head_q} + {1'b0, fill_q};
    if (tail_sum >= (FillW + 1)'(QueueDepth)) begin
      tail_sum = tail_sum - (FillW + 1)'(QueueDepth);
    end
    tail = tail_sum[PtrW-1:0];
  end

  // Advance head and fill
  always_comb begin
    head_d = head_q;
    fill_d = fill_q;
    if (pop_i) begin
      head_d = (head_q == PtrW'(QueueDepth - 1)) ? '0 : head_q + PtrW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   fill_d = fill_q + FillW'(1);
      2'b01:   fill_d = fill_q - FillW'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  tqwa_ram #(
    .Width (ItemWidth),
    .Depth (QueueDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_i),
    .waddr_i (tail),
    .wdata_i (push_data_i),
    .re_i    (pop_i),
    .raddr_i (head_q),
    .rdata_o (pop_data_o)
  );

endmodule

`default_nettype wire
